// ----- design/cet_pkg.sv -----
// Shared types for the CSV escape tokenizer: result kinds and result records.
// No dependencies; imported by the decoder, the result queue and the top level.
package cet_pkg;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        KIND_DATA       = 2'd0,
        KIND_FIELD_END  = 2'd1,
        KIND_RECORD_END = 2'd2,
        KIND_INPUT_END  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_result;

    // Decoder outcome for one item: up to two results, in order.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_dec_out;

endpackage

// ----- design/cet_decode.sv -----
// Parser state and per-item decode logic of the CSV escape tokenizer.
// Depends on cet_pkg for the result kinds and records.
module cet_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_byte,
    input  logic              i_eoi,
    output cet_pkg::t_dec_out o_dec
);
    import cet_pkg::*;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_LOW_N = 8'h6E;
    localparam logic [7:0] CH_LOW_R = 8'h72;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef enum logic [2:0] {
        PH_LINE = 3'd0,
        PH_COMM = 3'd1,
        PH_BODY = 3'd2,
        PH_ESC  = 3'd3,
        PH_HEX1 = 3'd4,
        PH_HEX2 = 3'd5,
        PH_OCT1 = 3'd6,
        PH_OCT2 = 3'd7
    } t_phase;

    t_phase     r_phase, n_phase;
    logic       r_quoted, n_quoted;
    logic       r_skip, n_skip;
    logic [7:0] r_partial, n_partial;

    logic       body;
    logic [7:0] diff;
    t_dec_out   dec;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        begin
            v = 8'd0;
            if (c inside {[8'h30:8'h39]}) v = c - 8'h30;
            else if (c inside {[8'h41:8'h46]}) v = c - 8'h37;
            else if (c inside {[8'h61:8'h66]}) v = c - 8'h57;
            hex_value = v[3:0];
        end
    endfunction

    function automatic t_result mk(input t_kind kind, input logic [7:0] data);
        t_result r;
        begin
            r.kind = kind;
            r.data = data;
            r.last = 1'b0;
            mk = r;
        end
    endfunction

    assign diff = i_byte - CH_ZERO;

    always_comb begin
        n_phase   = r_phase;
        n_quoted  = r_quoted;
        n_skip    = r_skip;
        n_partial = r_partial;
        body      = 1'b0;
        dec       = '0;

        if (i_eoi) begin
            // End of text: drop any partial record, return to reset state.
            n_phase    = PH_LINE;
            n_quoted   = 1'b0;
            n_skip     = 1'b0;
            n_partial  = 8'd0;
            dec.count  = 2'd1;
            dec.res0   = mk(KIND_INPUT_END, 8'd0);
        end else if (r_skip) begin
            n_skip = 1'b0;
        end else begin
            case (r_phase)
                PH_LINE: begin
                    if (i_byte == CH_CR || i_byte == CH_LF) begin
                        n_phase = PH_LINE;
                    end else if (i_byte == CH_SEMI) begin
                        n_phase = PH_COMM;
                    end else begin
                        n_phase = PH_BODY;
                        body    = 1'b1;
                    end
                end
                PH_COMM: begin
                    if (i_byte == CH_LF) n_phase = PH_LINE;
                end
                PH_ESC: begin
                    n_phase = PH_BODY;
                    if (i_byte == CH_CR) begin
                        n_skip = 1'b1;
                    end else if (i_byte == CH_LF) begin
                        n_phase = PH_BODY;
                    end else if (i_byte == CH_LOW_N) begin
                        dec.count = 2'd1;
                        dec.res0  = mk(KIND_DATA, CH_LF);
                    end else if (i_byte == CH_LOW_R) begin
                        dec.count = 2'd1;
                        dec.res0  = mk(KIND_DATA, CH_CR);
                    end else if (i_byte == CH_LOW_X) begin
                        n_phase = PH_HEX1;
                    end else if (i_byte inside {[8'h30:8'h37]}) begin
                        n_partial = {diff[1:0], 6'd0};
                        n_phase   = PH_OCT1;
                    end else begin
                        dec.count = 2'd1;
                        dec.res0  = mk(KIND_DATA, i_byte);
                    end
                end
                PH_HEX1: begin
                    n_partial = {4'd0, hex_value(i_byte)};
                    n_phase   = PH_HEX2;
                end
                PH_HEX2: begin
                    dec.count = 2'd1;
                    dec.res0  = mk(KIND_DATA, {r_partial[3:0], hex_value(i_byte)});
                    n_partial = 8'd0;
                    n_phase   = PH_BODY;
                end
                PH_OCT1: begin
                    n_partial = r_partial + {diff[4:0], 3'd0};
                    n_phase   = PH_OCT2;
                end
                PH_OCT2: begin
                    dec.count = 2'd1;
                    dec.res0  = mk(KIND_DATA, r_partial + diff);
                    n_partial = 8'd0;
                    n_phase   = PH_BODY;
                end
                default: begin
                    n_phase = PH_BODY;
                    body    = 1'b1;
                end
            endcase

            if (body) begin
                if (i_byte == CH_QUOTE) begin
                    n_quoted = ~r_quoted;
                end else if (i_byte == CH_COMMA) begin
                    dec.count = 2'd1;
                    dec.res0  = r_quoted ? mk(KIND_DATA, CH_COMMA)
                                         : mk(KIND_FIELD_END, 8'd0);
                end else if (i_byte == CH_BSLASH) begin
                    n_phase = PH_ESC;
                end else if (i_byte == CH_CR || i_byte == CH_LF) begin
                    if (i_byte == CH_CR) n_skip = 1'b1;
                    if (r_quoted) begin
                        dec.count = 2'd2;
                        dec.res0  = mk(KIND_DATA, CH_CR);
                        dec.res1  = mk(KIND_DATA, CH_LF);
                    end else begin
                        dec.count = 2'd1;
                        dec.res0  = mk(KIND_RECORD_END, 8'd0);
                        n_phase   = PH_LINE;
                    end
                end else begin
                    dec.count = 2'd1;
                    dec.res0  = mk(KIND_DATA, i_byte);
                end
            end
        end

        // Flag the final result of this item.
        if (dec.count == 2'd1) dec.res0.last = 1'b1;
        if (dec.count == 2'd2) dec.res1.last = 1'b1;
    end

    assign o_dec = dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LINE;
            r_quoted  <= 1'b0;
            r_skip    <= 1'b0;
            r_partial <= 8'd0;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_quoted  <= n_quoted;
            r_skip    <= n_skip;
            r_partial <= n_partial;
        end
    end

endmodule

// ----- design/cet_result_queue.sv -----
// Small result queue: takes up to two results per cycle, hands out one.
// Depends on cet_pkg for the result record type.
module cet_result_queue #(
    parameter int DEPTH = cet_pkg::QUEUE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [1:0]                   i_push_count,
    input  cet_pkg::t_result             i_res0,
    input  cet_pkg::t_result             i_res1,
    input  logic                         i_pop,
    output logic [$clog2(DEPTH+1)-1:0]   o_count,
    output cet_pkg::t_result             o_head
);
    import cet_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_result          r_slot [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic [PW-1:0]    wr_plus1;
    logic             do_pop;

    function automatic logic [PW-1:0] step(input logic [PW-1:0] p);
        begin
            step = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
        end
    endfunction

    assign wr_plus1 = step(r_wr);
    assign do_pop   = i_pop && (r_count != '0);

    always_comb begin
        n_wr    = r_wr;
        n_rd    = do_pop ? step(r_rd) : r_rd;
        n_count = r_count + CW'(i_push_count) - CW'(do_pop);
        if (i_push_count == 2'd1) n_wr = wr_plus1;
        if (i_push_count == 2'd2) n_wr = step(wr_plus1);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) r_slot[r_wr] <= i_res0;
        if (i_push_count == 2'd2) r_slot[wr_plus1] <= i_res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    assign o_count = r_count;
    assign o_head  = r_slot[r_rd];

endmodule

// ----- design/csv_escape_tokenizer.sv -----
// Top level of the CSV escape tokenizer: input register, decoder, result queue.
// Depends on cet_pkg, cet_decode and cet_result_queue.
//
// One raw byte (or an end-of-input mark) enters per item and the block takes a
// new item every cycle while o_in_stall is low. Each item passes the input
// register, is decoded combinationally against the parser state and lands in a
// small result queue whose head drives the output ports, so the first result
// reaches the output ports through the input register and then the queue. Most
// items give zero or one result; a line break inside quotes gives two (CR, LF),
// and since the output port moves one result per cycle while i_out_stall is low,
// a run of such items is paced by the output side. An item waits in the input
// register while the queue lacks room for all its results.
// Result kinds: data byte, field end, record end (last field of a record) and
// input end; last_of_run marks the final result caused by an item. End of input
// discards any partial record and returns the parser to its reset state.
module csv_escape_tokenizer #(
    parameter int QUEUE_DEPTH = cet_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_out_kind,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);
    import cet_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // input register
    logic          r_s1_valid;
    logic [7:0]    r_s1_byte;
    logic          r_s1_eoi;

    t_dec_out      dec;
    t_result       head;
    logic [CW-1:0] q_count;
    logic [CW:0]   room_need;
    logic          take;
    logic          load;
    logic [1:0]    push_count;

    // Hand the held item to the decoder only if all its results fit.
    assign room_need = {1'b0, q_count} + (CW + 1)'(dec.count);
    assign take      = r_s1_valid && (room_need <= (CW + 1)'(QUEUE_DEPTH));
    assign push_count = take ? dec.count : 2'd0;

    // Stall only while a held item cannot advance.
    assign o_in_stall = r_s1_valid && !take;
    assign load       = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (load) begin
            r_s1_valid <= 1'b1;
        end else if (take) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Payload holds no reset; capture on load only.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_s1_byte <= i_in_byte;
            r_s1_eoi  <= i_end_of_input;
        end
    end

    cet_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (r_s1_byte),
        .i_eoi   (r_s1_eoi),
        .o_dec   (dec)
    );

    cet_result_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (push_count),
        .i_res0       (dec.res0),
        .i_res1       (dec.res1),
        .i_pop        (!i_out_stall),
        .o_count      (q_count),
        .o_head       (head)
    );

    // Present the queue head.
    assign o_out_valid   = (q_count != '0);
    assign o_out_kind    = head.kind;
    assign o_out_byte    = head.data;
    assign o_last_of_run = head.last;

endmodule
